// File: hdl/rrqs_pkg.sv
// rrqs_pkg: shared types, constants and record codes of the round-robin scheduler
// used by every module under hdl except rrqs_ram, no dependencies of its own

package rrqs_pkg;

  // default queue depth and quantum after reset
  localparam int unsigned QueueDepthDefault = 16;
  localparam logic [7:0]  QuantumReset      = 8'd4;

  // record kinds on the result stream
  typedef enum logic [1:0] {
    KIND_FINISH = 2'd0,
    KIND_SLICE  = 2'd1,
    KIND_IDLE   = 2'd2,
    KIND_DROP   = 2'd3
  } kind_e;

  // one ready-queue entry
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] remaining;
    logic [15:0] burst;
    logic [31:0] arrival;
    logic [31:0] response;
    logic        responded;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // one result record
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  task_id;
    logic [15:0] run_length;
    logic [31:0] arrival_tick;
    logic [31:0] turnaround;
    logic [31:0] wait_total;
    logic [31:0] response_total;
    logic        last;
  } record_t;

  // controller commands to the datapath
  typedef struct packed {
    logic take;    // tick transfer accepted, head read issued
    logic exec;    // head entry available, evaluate the tick
    logic commit;  // write back head entry and load records
  } cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic obuf_empty;
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EXEC   = 2'd1,
    ST_COMMIT = 2'd2
  } state_e;

endpackage

// File: hdl/round_robin_quantum_scheduler.sv
// round_robin_quantum_scheduler: top level of the round-robin time-slice scheduler
// depends on rrqs_pkg, rrqs_ctrl, rrqs_dp (and rrqs_ram below it)
//
//   channel  | direction | handshake              | content
//   ---------+-----------+------------------------+--------------------------------
//   s_axis   | in        | tvalid/tready          | one tick, optional task arrival
//   m_axis   | out       | tvalid/tready, tlast   | finish/slice/idle/drop records
//   cfg      | in        | cfg_we_i               | quantum
//
// each tick passes through three steps: accept with head read, evaluate, commit.
// commit waits until the two-record output buffer has drained, so a stalled
// result side holds the next tick at most until its records are taken.
// reset clears pointers, counters and the buffer fill count at once; no clearing pass.
// queue entries live in a RAM with registered read, read once per tick.

module round_robin_quantum_scheduler
  import rrqs_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // arrival_id[7:0], arrival_burst[23:8]
  input  logic [0:0]   s_axis_tuser,   // arrival_valid[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [151:0] m_axis_tdata,   // task_id, run_length, arrival_tick,
                                       // turnaround, wait_total, response_total
  output logic [1:0]   m_axis_tuser,   // record_kind[1:0]
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;
  record_t rec;

  // sequencer
  rrqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // datapath
  rrqs_dp #(.QueueDepth(QueueDepth)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .arr_valid_i (s_axis_tuser[0]),
    .arr_id_i    (s_axis_tdata[7:0]),
    .arr_burst_i (s_axis_tdata[23:8]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rec_o       (rec),
    .rec_valid_o (m_axis_tvalid),
    .rec_ready_i (m_axis_tready)
  );

  // record packing
  assign m_axis_tdata = {rec.response_total, rec.wait_total, rec.turnaround,
                         rec.arrival_tick, rec.run_length, rec.task_id};
  assign m_axis_tuser = rec.kind;
  assign m_axis_tlast = rec.last;

endmodule

// File: hdl/rrqs_ram.sv
// rrqs_ram: generic single-write, single-read RAM with registered read data
// no package dependencies

module rrqs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rrqs_ctrl.sv
// rrqs_ctrl: tick sequencer of the scheduler (idle, evaluate, commit)
// depends on rrqs_pkg for state and command types

module rrqs_ctrl
  import rrqs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output buffer has drained
        if (status_i.obuf_empty) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/rrqs_dp.sv
// rrqs_dp: scheduler datapath: queue pointers, counters, entry RAM, record buffer
// depends on rrqs_pkg and rrqs_ram

module rrqs_dp
  import rrqs_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic        arr_valid_i,
  input  logic [7:0]  arr_id_i,
  input  logic [15:0] arr_burst_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  output record_t     rec_o,
  output logic        rec_valid_o,
  input  logic        rec_ready_i
);

  localparam int unsigned AW = $clog2(QueueDepth);
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam logic [CW:0] DepthW = (CW + 1)'(QueueDepth);

  // (head + offset) mod depth, sum stays below twice the depth
  function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
    logic [CW:0] r;
    r = (s >= DepthW) ? (s - DepthW) : s;
    return r[AW-1:0];
  endfunction

  logic [AW-1:0] head_q;
  logic [CW-1:0] count_q;
  logic [31:0]   tick_q, idle_start_q;
  logic [8:0]    spp_q;      // slice position plus one
  logic [7:0]    quantum_q;
  logic          av_q;
  logic [7:0]    aid_q;
  logic [15:0]   aburst_q;

  logic          wb_en_q;
  logic [AW-1:0] wb_addr_q;
  entry_t        wb_data_q;
  record_t       rec0_q, rec1_q;
  logic [1:0]    nrec_q;

  record_t       obuf_q [2];
  logic [1:0]    ocnt_q;

  entry_t        head_e, upd_e, new_e;
  logic [EntryW-1:0] rdata;
  logic          ran, done, drop, app, idle, rot, emptied;
  logic [AW-1:0] h1, app_addr, rot_addr, head2;
  logic [CW-1:0] c1, c2;
  logic [8:0]    spp1, spp2;
  logic [8:0]    qe;
  logic [31:0]   gap;
  logic [31:0]   elapsed;
  logic [15:0]   eff_burst;
  record_t       r_fin, r_idle, r_drop, r_slice, r0, r1;
  logic [1:0]    nrec;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EntryW-1:0] ram_wdata;

  // entry store
  rrqs_ram #(.Width(EntryW), .Depth(QueueDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.take),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  assign head_e = entry_t'(rdata);

  // tick evaluation
  always_comb begin
    ran       = (count_q != '0);
    done      = ran && (head_e.remaining <= 16'd1);
    upd_e     = head_e;
    upd_e.remaining = done ? 16'd0 : head_e.remaining - 16'd1;
    upd_e.responded = 1'b1;
    elapsed   = tick_q - head_e.arrival;
    if (!head_e.responded) begin
      upd_e.response = elapsed - 32'd1;
    end
    eff_burst = (head_e.burst == 16'd0) ? 16'd1 : head_e.burst;

    h1      = done ? wrap((CW + 1)'(head_q) + (CW + 1)'(1)) : head_q;
    c1      = count_q - CW'(done);
    emptied = done && (c1 == '0);
    drop    = av_q && ((CW + 1)'(c1) == DepthW);
    app     = av_q && !drop;
    c2      = c1 + CW'(app);
    idle    = app && (c2 == CW'(1));
    app_addr = wrap((CW + 1)'(h1) + (CW + 1)'(c1));
    rot_addr = wrap((CW + 1)'(h1) + (CW + 1)'(c2));

    qe   = (quantum_q == 8'd0) ? 9'd1 : {1'b0, quantum_q};
    spp1 = (done || idle) ? 9'd0 : spp_q;
    rot  = (c2 != '0) && (spp1 >= qe);
    head2 = rot ? wrap((CW + 1)'(h1) + (CW + 1)'(1)) : h1;
    spp2 = rot ? 9'd0 : spp1;
    if (spp2 != 9'd256) begin
      spp2 = spp2 + 9'd1;
    end

    gap = emptied ? 32'd0 : tick_q - idle_start_q;

    new_e           = '0;
    new_e.id        = aid_q;
    new_e.remaining = aburst_q;
    new_e.burst     = aburst_q;
    new_e.arrival   = tick_q;

    // candidate records
    r_fin                = '0;
    r_fin.kind           = KIND_FINISH;
    r_fin.task_id        = head_e.id;
    r_fin.run_length     = {7'd0, spp_q};
    r_fin.arrival_tick   = head_e.arrival;
    r_fin.turnaround     = elapsed;
    r_fin.wait_total     = elapsed - {16'd0, eff_burst};
    r_fin.response_total = upd_e.response;

    r_idle            = '0;
    r_idle.kind       = KIND_IDLE;
    r_idle.run_length = (gap > 32'h0000_FFFF) ? 16'hFFFF : gap[15:0];

    r_drop              = '0;
    r_drop.kind         = KIND_DROP;
    r_drop.task_id      = aid_q;
    r_drop.arrival_tick = tick_q;

    r_slice              = '0;
    r_slice.kind         = KIND_SLICE;
    r_slice.task_id      = head_e.id;
    r_slice.run_length   = {7'd0, qe};
    r_slice.arrival_tick = head_e.arrival;

    // order: finish, idle, drop, slice; at most two
    r0 = r_slice;
    if (done) begin
      r0 = r_fin;
    end else if (idle) begin
      r0 = r_idle;
    end else if (drop) begin
      r0 = r_drop;
    end
    r1 = (done && idle) ? r_idle : r_slice;
    nrec = 2'(done) + 2'(idle) + 2'(drop) + 2'(rot);
    if (nrec == 2'd1) begin
      r0.last = 1'b1;
    end
    r1.last = 1'b1;
  end

  // RAM write port: arrival while evaluating, head write-back on commit
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wb_addr_q;
    ram_wdata = wb_data_q;
    if (cmd_i.exec && app) begin
      ram_we    = 1'b1;
      ram_waddr = app_addr;
      ram_wdata = new_e;
    end else if (cmd_i.commit && wb_en_q) begin
      ram_we = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      count_q      <= '0;
      tick_q       <= '0;
      idle_start_q <= '0;
      spp_q        <= '0;
      quantum_q    <= QuantumReset;
      wb_en_q      <= 1'b0;
      nrec_q       <= '0;
      ocnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        head_q  <= head2;
        count_q <= c2;
        tick_q  <= tick_q + 32'd1;
        spp_q   <= spp2;
        wb_en_q <= ran && !done;
        nrec_q  <= nrec;
        if (emptied || idle) begin
          idle_start_q <= tick_q;
        end
      end
      // output buffer count
      if (cmd_i.commit) begin
        ocnt_q <= nrec_q;
      end else if (rec_valid_o && rec_ready_i) begin
        ocnt_q <= ocnt_q - 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      av_q     <= arr_valid_i;
      aid_q    <= arr_id_i;
      aburst_q <= arr_burst_i;
    end
    if (cmd_i.exec) begin
      wb_addr_q <= rot ? rot_addr : head_q;
      wb_data_q <= upd_e;
      rec0_q    <= r0;
      rec1_q    <= r1;
    end
    if (cmd_i.commit) begin
      obuf_q[0] <= rec0_q;
      obuf_q[1] <= rec1_q;
    end else if (rec_valid_o && rec_ready_i) begin
      obuf_q[0] <= obuf_q[1];
    end
  end

  assign rec_o               = obuf_q[0];
  assign rec_valid_o         = (ocnt_q != 2'd0);
  assign status_o.obuf_empty = (ocnt_q == 2'd0);

endmodule

// File: hdl/rrqs_checker.sv
// rrqs_checker: port-level assertions for the scheduler, bound to the top level
// depends on rrqs_pkg for record kinds

module rrqs_checker
  import rrqs_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [151:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  // stalled record holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("record changed under stall");

  // idle-gap records carry no task
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_IDLE) |->
      (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[151:24] == '0))
    else $error("idle record with task fields");

  // drop records carry no run or statistics
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_DROP) |->
      (m_axis_tdata[23:8] == 16'd0) && (m_axis_tdata[151:56] == '0))
    else $error("drop record with statistics");

  // a slice record is always the final record of its tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_SLICE) |-> m_axis_tlast)
    else $error("slice record not last");

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: dv/round_robin_quantum_scheduler_tb.sv
// round_robin_quantum_scheduler_tb: self-checking testbench of the round-robin scheduler
// depends on rrqs_pkg and round_robin_quantum_scheduler; a built-in scheduler model
// predicts every record, random stalls on both streams

module round_robin_quantum_scheduler_tb;
  import rrqs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = QueueDepthDefault;
  localparam int unsigned StallLimit = 2000;
  localparam int NoKind = -1;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [151:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we_i = 1'b0;
  logic [7:0]   cfg_wdata_i = '0;

  always #5 clk_i = ~clk_i;

  round_robin_quantum_scheduler DUT (.*);

  // scheduler model state
  logic [7:0]  sch_id[Depth];
  logic [15:0] sch_remaining[Depth];
  logic [31:0] sch_arrival[Depth];
  logic [31:0] sch_wait[Depth];
  logic [31:0] sch_response[Depth];
  logic        sch_responded[Depth];
  int unsigned sch_head, sch_count;
  logic [31:0] sch_tick, sch_idle_start, sch_last_arrival;
  logic [7:0]  sch_last_id, sch_quantum;
  int          sch_slice;

  record_t     records_due[$];
  int          errors = 0;
  bit          send_gaps = 1'b0;
  bit          recv_stalls = 1'b0;

  function automatic record_t make_record(kind_e k, logic [7:0] id, logic [15:0] run,
                                          logic [31:0] arr, logic [31:0] turn,
                                          logic [31:0] wt, logic [31:0] resp);
    record_t r;
    r = '{k, id, run, arr, turn, wt, resp, 1'b0};
    return r;
  endfunction

  // one tick of the scheduler, records appended to records_due
  task automatic schedule_tick(bit av, logic [7:0] aid, logic [15:0] aburst);
    record_t     recs[$];
    bit          done;
    int unsigned h, s, from, to, q;
    logic [31:0] t, gap;
    done = 1'b0;
    t = sch_tick;
    // head runs one unit
    if (sch_count != 0) begin
      h = sch_head;
      sch_last_id = sch_id[h];
      sch_last_arrival = sch_arrival[h];
      done = sch_remaining[h] <= 16'd1;
      sch_remaining[h] = done ? 16'd0 : sch_remaining[h] - 16'd1;
      sch_responded[h] = 1'b1;
    end
    // waiting tasks accumulate
    for (int i = 1; i < sch_count; i++) begin
      s = (sch_head + i) % Depth;
      if (!sch_responded[s]) sch_response[s]++;
      sch_wait[s]++;
    end
    // finished head leaves
    if (sch_count != 0 && done) begin
      h = sch_head;
      recs.insert(recs.size(), make_record(KIND_FINISH, sch_id[h],
                                 sch_slice < 0 ? 16'd0 : 16'(sch_slice + 1),
                                 sch_arrival[h], t - sch_arrival[h], sch_wait[h],
                                 sch_response[h]));
      sch_head = (sch_head + 1) % Depth;
      sch_count--;
      sch_slice = -1;
      if (sch_count == 0) sch_idle_start = t;
    end
    // arrival, dropped when the queue is full
    if (av) begin
      if (sch_count >= Depth) begin
        recs.insert(recs.size(), make_record(KIND_DROP, aid, 16'd0, t, '0, '0, '0));
      end else begin
        s = (sch_head + sch_count) % Depth;
        sch_id[s] = aid;
        sch_remaining[s] = aburst;
        sch_arrival[s] = t;
        sch_wait[s] = '0;
        sch_response[s] = '0;
        sch_responded[s] = 1'b0;
        sch_count++;
        if (sch_count == 1) begin
          gap = t - sch_idle_start;
          if (gap > 32'hFFFF) gap = 32'hFFFF;
          recs.insert(recs.size(), make_record(KIND_IDLE, 8'd0, gap[15:0], '0, '0, '0, '0));
          sch_idle_start = t;
          sch_slice = -1;
        end
      end
    end
    // quantum expiry rotates the head to the tail
    q = (sch_quantum == 0) ? 1 : sch_quantum;
    if (sch_count != 0 && sch_slice >= int'(q) - 1) begin
      from = sch_head;
      to = (sch_head + sch_count) % Depth;
      sch_id[to] = sch_id[from];
      sch_remaining[to] = sch_remaining[from];
      sch_arrival[to] = sch_arrival[from];
      sch_wait[to] = sch_wait[from];
      sch_response[to] = sch_response[from];
      sch_responded[to] = sch_responded[from];
      sch_head = (sch_head + 1) % Depth;
      sch_slice = -1;
      recs.insert(recs.size(), make_record(KIND_SLICE, sch_last_id, 16'(q),
                                           sch_last_arrival, '0, '0, '0));
    end
    if (sch_slice < 255) sch_slice++;
    sch_tick = t + 1;
    if (recs.size() > 0) recs[recs.size() - 1].last = 1'b1;
    foreach (recs[i]) records_due.insert(records_due.size(), recs[i]);
  endtask

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  // one tick transfer; tvalid stays high between back-to-back ticks
  task automatic send_tick(bit av, logic [7:0] aid, logic [15:0] aburst, int kind_chk);
    int unsigned gap;
    int          first;
    gap = (send_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= av;
    s_axis_tdata <= {aburst, aid};
    do @(posedge clk_i); while (!s_axis_tready);
    first = records_due.size();
    schedule_tick(av, aid, aburst);
    if (kind_chk != NoKind && (records_due.size() <= first ||
        int'(records_due[first].kind) != kind_chk)) begin
      errors++;
      if (errors <= 10)
        $display("directed tick %0d: expected record kind %0d not produced",
                 sch_tick - 1, kind_chk);
    end
  endtask

  // drain outstanding records, then write the quantum while idle
  task automatic set_quantum(logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    while (records_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sch_quantum = value;
  endtask

  // result side ready with random stalls
  int unsigned hold_cnt = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
      hold_cnt <= pick_gap() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare every record transfer with the oldest prediction
  always @(posedge clk_i) begin
    record_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {kind_e'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[23:8],
             m_axis_tdata[55:24], m_axis_tdata[87:56], m_axis_tdata[119:88],
             m_axis_tdata[151:120], m_axis_tlast};
      if (records_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected record %h", got);
      end else begin
        want = records_due.pop_front();
        if (got.kind !== want.kind || got.task_id !== want.task_id ||
            got.run_length !== want.run_length || got.arrival_tick !== want.arrival_tick ||
            got.turnaround !== want.turnaround || got.wait_total !== want.wait_total ||
            got.response_total !== want.response_total || got.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display({"record mismatch: kind %0d/%0d id %0d/%0d run %0d/%0d arr %0d/%0d",
                      "\n  turn %0d/%0d wait %0d/%0d resp %0d/%0d last %0d/%0d"},
                     want.kind, got.kind, want.task_id, got.task_id, want.run_length,
                     got.run_length, want.arrival_tick, got.arrival_tick,
                     want.turnaround, got.turnaround, want.wait_total, got.wait_total,
                     want.response_total, got.response_total, want.last, got.last);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  typedef struct {
    bit          av;
    logic [7:0]  id;
    logic [15:0] burst;
    int          kind;
  } tick_row_t;

  tick_row_t directed[$];

  initial begin
    logic [15:0] burst;
    logic [7:0]  quanta[5];
    int unsigned arrive_pct;
    sch_head = 0; sch_count = 0; sch_tick = '0; sch_slice = -1;
    sch_idle_start = '0; sch_last_id = '0; sch_last_arrival = '0;
    sch_quantum = QuantumReset;

    // lone arrival after reset, zero burst, then a full queue and a drop
    directed.insert(directed.size(), '{1'b1, 8'd0, 16'd1, int'(KIND_IDLE)});
    directed.insert(directed.size(), '{1'b0, 8'd0, 16'd0, int'(KIND_FINISH)});
    directed.insert(directed.size(), '{1'b1, 8'd255, 16'd0, int'(KIND_IDLE)});
    directed.insert(directed.size(), '{1'b0, 8'd0, 16'd0, int'(KIND_FINISH)});
    for (int i = 0; i < 16; i++)
      directed.insert(directed.size(), '{1'b1, 8'(i + 1), 16'd20, NoKind});
    directed.insert(directed.size(), '{1'b1, 8'd1, 16'd20, int'(KIND_DROP)});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send_tick(directed[i].av, directed[i].id, directed[i].burst, directed[i].kind);

    // random phases over several quanta, zero and the extremes included
    quanta = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(2, 9)), QuantumReset};
    foreach (quanta[p]) begin
      set_quantum(quanta[p]);
      send_gaps = (p != 0);
      recv_stalls = (p != 1);
      arrive_pct = $urandom_range(20, 90);
      for (int n = 0; n < 170; n++) begin
        burst = ($urandom_range(0, 59) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        send_tick($urandom_range(1, 100) <= arrive_pct, 8'($urandom), burst, NoKind);
      end
    end

    // longest burst joins the queue, then a short tail
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    send_tick(1'b1, 8'd77, 16'hFFFF, NoKind);
    send_tick(1'b1, 8'd200, 16'd3, NoKind);
    repeat (4) send_tick(1'b0, 8'd0, 16'd0, NoKind);

    s_axis_tvalid <= 1'b0;
    while (records_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
hdl/rrqs_pkg.sv
hdl/rrqs_ram.sv
hdl/rrqs_ctrl.sv
hdl/rrqs_dp.sv
hdl/round_robin_quantum_scheduler.sv
hdl/rrqs_checker.sv
dv/round_robin_quantum_scheduler_tb.sv
